// File: hdl/emfd_pkg.sv
// Shared types and constants for the echo matched-filter detector.
package emfd_pkg;

	// Command codes carried in the input tuser field.
	localparam logic [1:0] CMD_LOAD_TEMPLATE = 2'd0;
	localparam logic [1:0] CMD_LOAD_BUFFER   = 2'd1;
	localparam logic [1:0] CMD_START         = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TEMPLATE_LENGTH  = 2'd0;
	localparam logic [1:0] CFG_BUFFER_LENGTH    = 2'd1;
	localparam logic [1:0] CFG_DETECT_THRESHOLD = 2'd2;
	localparam logic [1:0] CFG_MAX_ECHOES       = 2'd3;

	// Register reset values.
	localparam logic [13:0] TLEN_RESET = 14'd4410;
	localparam logic [16:0] BLEN_RESET = 17'd44100;
	localparam logic [19:0] THR_RESET  = 20'd6554;
	localparam logic [4:0]  MAXE_RESET = 5'd20;

	// Most echoes reported in one run.
	localparam logic [4:0] MAX_REPORT = 5'd20;

	// Amplitude format: unsigned Q4.16.
	localparam int AMP_W    = 20;
	localparam int AMP_FRAC = 16;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_CORR,
		ST_DRAIN,
		ST_DIV,
		ST_DIVW,
		ST_EMIT,
		ST_SUB,
		ST_SDRAIN
	} state_t;

	// Status returned by the divider.
	typedef struct packed {
		logic done;
		logic rem_nz;
	} div_stat_t;

endpackage

// File: hdl/emfd_mul.sv
// Shared registered signed multiplier used by correlation and subtraction.
module emfd_mul import emfd_pkg::*; #(
	parameter int AW = 21,
	parameter int BW = 16
) (
	input  logic                     clk,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p_s2
);

	// One product per cycle, registered before any further use.
	always_ff @(posedge clk) begin
		p_s2 <= a * b;
	end

endmodule

// File: hdl/emfd_div.sv
// Restoring divider that forms the amplitude quotient one bit per cycle.
module emfd_div import emfd_pkg::*; #(
	parameter int DW = 67,
	parameter int QW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] q,
	output div_stat_t     stat
);

	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsh_q;
	logic [QW-1:0] q_q;

	// Control: a run of QW compare and subtract steps after start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: the quotient fits in QW bits, so the divisor starts QW-1 places up.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= den << (QW - 1);
			q_q   <= '0;
		end else if (busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[QW-2:0], 1'b1};
			end else begin
				q_q   <= {q_q[QW-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign q           = q_q;
	assign stat.done   = done_q;
	assign stat.rem_nz = (rem_q != '0);

endmodule

// File: hdl/echo_matched_filter_detector_top.sv
// Top level of the echo matched-filter detector: stores, sequencer and datapath.
//
//  channel  | direction | handshake          | contents
//  s_*      | in        | s_tvalid/s_tready  | command, sample index, sample value
//  m_*      | out       | m_tvalid/m_tready  | found, position, amplitude, last
//  cfg_*    | in        | cfg_we             | register index and write data
//
// A load word does not make the block busy; it stays ready for the next word.
// A start word runs a search over the m-n+1 lags of the template against the buffer through the
// single multiplier and the two store read ports, then a drain of the pipeline and a division,
// and per echo a subtract pass over the template, for n template and m buffer samples.
// Reset clears control state only; the stores are not cleared.
// A stalled result holds in the output register; the sequencer waits before the next one.
module echo_matched_filter_detector_top import emfd_pkg::*; #(
	parameter int TEMPLATE_DEPTH = 8192,
	parameter int BUFFER_DEPTH   = 65536,
	parameter int SAMPLE_WIDTH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // sample_index[15:0], sample_value[31:16]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // found[0], position[16:1], amplitude[36:17], zero[39:37]
	output logic        m_tlast
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int TAW = $clog2(TEMPLATE_DEPTH);
	localparam int BAW = $clog2(BUFFER_DEPTH);
	localparam int NW  = $clog2(TEMPLATE_DEPTH + 1);
	localparam int PKW = 2 * SW + TAW + 1;
	localparam int MAW = (SW > AMP_W + 1) ? SW : AMP_W + 1;
	localparam int PW  = MAW + SW;
	localparam int QW  = AMP_FRAC + 2;
	localparam int DW  = PKW + AMP_FRAC + 2;

	// Saturate a wide signed value into the sample range.
	function automatic logic signed [SW-1:0] sat_w(input logic signed [PW+1:0] v);
		logic signed [PW+1:0] hi;
		logic signed [PW+1:0] lo;
		hi = $signed({{(PW + 3 - SW){1'b0}}, {(SW - 1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			return hi[SW-1:0];
		end else if (v < lo) begin
			return lo[SW-1:0];
		end
		return v[SW-1:0];
	endfunction

	// Configuration registers.
	logic [13:0] tlen_q;
	logic [16:0] blen_q;
	logic [19:0] thr_q;
	logic [4:0]  maxe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q <= TLEN_RESET;
			blen_q <= BLEN_RESET;
			thr_q  <= THR_RESET;
			maxe_q <= MAXE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEMPLATE_LENGTH:  tlen_q <= cfg_wdata[13:0];
				CFG_BUFFER_LENGTH:    blen_q <= cfg_wdata[16:0];
				CFG_DETECT_THRESHOLD: thr_q  <= cfg_wdata;
				CFG_MAX_ECHOES:       maxe_q <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// Effective lengths, clipped to the store depths, and the echo limit.
	logic [NW-1:0]  n_w;
	logic [4:0]     limit_w;
	logic           no_lag;
	logic [BAW-1:0] lag_end;
	logic [TAW-1:0] n_m1;
	int             n_i;
	int             m_i;

	always_comb begin
		n_i     = (int'(tlen_q) > TEMPLATE_DEPTH) ? TEMPLATE_DEPTH : int'(tlen_q);
		m_i     = (int'(blen_q) > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(blen_q);
		n_w     = NW'(n_i);
		limit_w = (maxe_q > MAX_REPORT) ? MAX_REPORT : maxe_q;
		no_lag  = (n_i == 0) || (n_i > m_i);
		lag_end = BAW'(m_i - n_i);
		n_m1    = TAW'(n_i - 1);
	end

	// Sequencer state and working registers.
	state_t          state_q;
	state_t          state_d;
	logic [BAW-1:0]  base_q;
	logic [TAW-1:0]  j_q;
	logic [4:0]      count_q;
	logic            pend_found_q;
	logic            pend_last_q;
	logic [AMP_W-1:0] amp_q;
	logic [PKW-1:0]  best_q;
	logic [BAW-1:0]  best_lag_q;
	logic signed [PKW-1:0] acc_q;

	// Input word decode.
	logic              in_acc;
	logic [15:0]       in_idx;
	logic signed [15:0] in_val;
	logic signed [PW+1:0] in_ext;
	logic              t_we;
	logic              bl_we;
	logic              start_acc;

	assign in_acc    = s_tvalid && s_tready;
	assign in_idx    = s_tdata[15:0];
	assign in_val    = $signed(s_tdata[31:16]);
	assign in_ext    = (PW + 2)'(in_val);
	assign t_we      = in_acc && (s_tuser == CMD_LOAD_TEMPLATE) && (int'(in_idx) < TEMPLATE_DEPTH);
	assign bl_we     = in_acc && (s_tuser == CMD_LOAD_BUFFER) && (int'(in_idx) < BUFFER_DEPTH);
	assign start_acc = in_acc && (s_tuser == CMD_START);

	// Divider interface.
	logic [DW-1:0]  div_num;
	logic [DW-1:0]  div_den;
	logic [QW-1:0]  div_q;
	div_stat_t      div_st;
	logic           div_start;
	logic [AMP_W-1:0] q_ext;
	logic           exceed;

	assign div_num = DW'({best_q, {(AMP_FRAC + 1){1'b0}}});
	assign div_den = DW'(n_w) << (2 * SW - 2);
	assign q_ext   = AMP_W'(div_q);
	assign exceed  = (q_ext > thr_q) || ((q_ext == thr_q) && div_st.rem_nz);

	emfd_div #(.DW(DW), .QW(QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.q      (div_q),
		.stat   (div_st)
	);

	// Pipeline stage flags.
	logic           s1_v, s1_first, s1_last, s1_sub;
	logic           s2_v, s2_first, s2_last, s2_sub;
	logic [BAW-1:0] s1_addr, s2_addr, s1_lag, s2_lag;
	logic signed [SW-1:0] tdat_s1;
	logic signed [SW-1:0] bdat_s1;
	logic signed [SW-1:0] buf_s2;
	logic signed [PW-1:0] prod_s2;

	// Issue stage signals.
	logic           iss_v;
	logic           iss_last;
	logic           out_free;
	logic           out_load;
	logic [BAW-1:0] b_raddr;
	logic           pipe_empty;

	assign iss_last   = (j_q == n_m1);
	assign b_raddr    = base_q + BAW'(j_q);
	assign out_free   = !m_tvalid || m_tready;
	assign pipe_empty = !s1_v && !s2_v;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_acc) begin
					state_d = (limit_w == 5'd0) ? ST_EMIT : ST_INIT;
				end
			end
			ST_INIT:   state_d = no_lag ? ST_EMIT : ST_CORR;
			ST_CORR: begin
				if (iss_last && (base_q == lag_end)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = pipe_empty ? ST_DIV : ST_DRAIN;
			ST_DIV:    state_d = (best_q == '0) ? ST_EMIT : ST_DIVW;
			ST_DIVW:   state_d = div_st.done ? ST_EMIT : ST_DIVW;
			ST_EMIT: begin
				if (out_free) begin
					state_d = pend_found_q ? ST_SUB : ST_IDLE;
				end
			end
			ST_SUB:    state_d = iss_last ? ST_SDRAIN : ST_SUB;
			ST_SDRAIN: begin
				if (pipe_empty) begin
					state_d = (count_q == limit_w) ? ST_IDLE : ST_INIT;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		iss_v     = (state_q == ST_CORR) || (state_q == ST_SUB);
		div_start = (state_q == ST_DIV) && (best_q != '0);
		out_load  = (state_q == ST_EMIT) && out_free;
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			pend_found_q <= 1'b0;
			pend_last_q  <= 1'b0;
			base_q       <= '0;
			j_q          <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (start_acc) begin
						count_q      <= '0;
						pend_found_q <= 1'b0;
					end
				end
				ST_INIT: begin
					base_q       <= '0;
					j_q          <= '0;
					pend_found_q <= 1'b0;
				end
				ST_CORR: begin
					if (iss_last) begin
						j_q    <= '0;
						base_q <= base_q + BAW'(1);
					end else begin
						j_q <= j_q + TAW'(1);
					end
				end
				ST_DIVW: begin
					if (div_st.done && exceed) begin
						pend_found_q <= 1'b1;
						pend_last_q  <= (5'(count_q + 5'd1) == limit_w);
						count_q      <= count_q + 5'd1;
					end
				end
				ST_EMIT: begin
					base_q <= best_lag_q;
					j_q    <= '0;
				end
				ST_SUB:  j_q <= j_q + TAW'(1);
				default: ;
			endcase
		end
	end

	// Amplitude of the current echo; the quotient never exceeds 2^17, so no clipping is needed.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIVW) && div_st.done && exceed) begin
			amp_q <= q_ext;
		end
	end

	// Template and buffer stores with registered reads.
	logic signed [SW-1:0] tmem [TEMPLATE_DEPTH];
	logic signed [SW-1:0] bmem [BUFFER_DEPTH];
	logic                 sub_we;
	logic signed [SW-1:0] sub_wdata;

	always_ff @(posedge clk) begin
		if (t_we) begin
			tmem[TAW'(in_idx)] <= sat_w(in_ext);
		end
		tdat_s1 <= tmem[j_q];
	end

	always_ff @(posedge clk) begin
		if (bl_we) begin
			bmem[BAW'(in_idx)] <= sat_w(in_ext);
		end else if (sub_we) begin
			bmem[s2_addr] <= sub_wdata;
		end
		bdat_s1 <= bmem[b_raddr];
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
		end else begin
			s1_v <= iss_v;
			s2_v <= s1_v;
		end
	end

	// Stage tags.
	always_ff @(posedge clk) begin
		s1_first <= (j_q == '0);
		s1_last  <= iss_last;
		s1_sub   <= (state_q == ST_SUB);
		s1_addr  <= b_raddr;
		s1_lag   <= base_q;
		s2_first <= s1_first;
		s2_last  <= s1_last;
		s2_sub   <= s1_sub;
		s2_addr  <= s1_addr;
		s2_lag   <= s1_lag;
		buf_s2   <= bdat_s1;
	end

	// The multiplier takes buffer by template in the search, amplitude by template in subtraction.
	logic signed [MAW-1:0] mul_a;

	always_comb begin
		mul_a = s1_sub ? $signed({1'b0, amp_q}) : MAW'(bdat_s1);
	end

	emfd_mul #(.AW(MAW), .BW(SW)) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (tdat_s1),
		.p_s2 (prod_s2)
	);

	// Correlation accumulate and peak tracking.
	logic signed [PKW-1:0] prod_ext;
	logic signed [PKW-1:0] sum;
	logic                  peak_upd;

	always_comb begin
		prod_ext = PKW'($signed(prod_s2[2*SW-1:0]));
		sum      = (s2_first ? '0 : acc_q) + prod_ext;
		peak_upd = s2_v && !s2_sub && s2_last && !sum[PKW-1] && (sum != '0)
			&& ($unsigned(sum) > best_q);
	end

	always_ff @(posedge clk) begin
		if (s2_v && !s2_sub) begin
			acc_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			best_lag_q <= '0;
		end else if (state_q == ST_INIT) begin
			best_q     <= '0;
			best_lag_q <= '0;
		end else if (peak_upd) begin
			best_q     <= $unsigned(sum);
			best_lag_q <= s2_lag;
		end
	end

	// Subtraction of the scaled template, rounded and saturated.
	logic signed [PW:0]   sub_v;
	logic signed [PW:0]   sub_d;
	logic signed [PW+1:0] sub_b;
	logic signed [PW+1:0] sub_dx;
	logic signed [PW+1:0] sub_diff;

	always_comb begin
		sub_v     = $signed({prod_s2[PW-1], prod_s2})
			+ $signed({{(PW - 16){1'b0}}, 17'h08000});
		sub_d     = sub_v >>> AMP_FRAC;
		sub_b     = (PW + 2)'(buf_s2);
		sub_dx    = (PW + 2)'(sub_d);
		sub_diff  = sub_b - sub_dx;
		sub_wdata = sat_w(sub_diff);
		sub_we    = s2_v && s2_sub;
	end

	// Output register.
	logic        out_v_q;
	logic [39:0] out_data_q;
	logic        out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (pend_found_q) begin
				out_data_q <= {3'b000, amp_q, 16'(best_lag_q), 1'b1};
				out_last_q <= pend_last_q;
			end else begin
				out_data_q <= '0;
				out_last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// File: hdl/emfd_chk.sv
// Port-level checker for the echo matched-filter detector, bound to the top level.
module emfd_chk import emfd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// A stalled result word holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// A result without an echo always closes the run.
	a_nf_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tlast)
		else $error("no-echo result without last");

	// A result without an echo carries zero position and amplitude.
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[39:1] == '0))
		else $error("no-echo result with nonzero fields");

	// A start word makes the block busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_START) |=> !s_tready)
		else $error("ready after start word");

endmodule

bind echo_matched_filter_detector_top emfd_chk u_emfd_chk (.*);
